// ===== rtl/pfif_pkg.sv =====
package pfif_pkg;

  localparam int PAGE_COUNT   = 8;
  localparam int COLUMN_COUNT = 128;
  localparam int ROW_COUNT    = PAGE_COUNT * 8;
  localparam int MEM_DEPTH    = PAGE_COUNT * COLUMN_COUNT;

  localparam int PAGE_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int COL_W  = $clog2(COLUMN_COUNT);
  localparam int ADDR_W = $clog2(MEM_DEPTH);

  // operation codes
  localparam logic OP_INVERT = 1'b0;
  localparam logic OP_PULL   = 1'b1;

  // display command bytes
  localparam logic [7:0] PAGE_CMD    = 8'hB0;
  localparam logic [7:0] COL_LO_CMD  = 8'h00;
  localparam logic [7:0] COL_HI_CMD  = 8'h10;
  localparam logic [7:0] NIBBLE_MASK = 8'h0F;

  // position within a page of the flush
  localparam logic [7:0] POS_PAGE   = 8'd0;
  localparam logic [7:0] POS_COL_LO = 8'd1;
  localparam logic [7:0] POS_COL_HI = 8'd2;
  localparam logic [7:0] POS_DATA   = 8'd3;

  typedef struct packed {
    logic clr_wr;
    logic start_inv;
    logic inv_rd;
    logic inv_wr;
    logic pull_rd;
    logic pull_out;
    logic res_imm;
    logic res_rej;
  } pfif_cmd_t;

  typedef struct packed {
    logic busy;
    logic rect_empty;
    logic clr_last;
    logic inv_last;
  } pfif_sts_t;

endpackage

// ===== rtl/pfif_if.sv =====
interface pfif_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [6:0] start_column;
  logic [5:0] start_row;
  logic [7:0] region_width;
  logic [7:0] region_height;

  modport source (output valid, operation, start_column, start_row, region_width,
                  region_height, input ready);
  modport sink   (input valid, operation, start_column, start_row, region_width,
                  region_height, output ready);
endinterface

interface pfif_out_if;
  logic       valid;
  logic       ready;
  logic       byte_valid;
  logic       is_pixel_data;
  logic [7:0] out_byte;
  logic       last_of_flush;
  logic       request_rejected;

  modport source (output valid, byte_valid, is_pixel_data, out_byte, last_of_flush,
                  request_rejected, input ready);
  modport sink   (input valid, byte_valid, is_pixel_data, out_byte, last_of_flush,
                  request_rejected, output ready);
endinterface

// ===== rtl/pfif_dp.sv =====
module pfif_dp import pfif_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  pfif_cmd_t  cmd,
  input  logic [6:0] start_column,
  input  logic [5:0] start_row,
  input  logic [7:0] region_width,
  input  logic [7:0] region_height,
  output pfif_sts_t  sts,
  output logic       byte_valid,
  output logic       is_pixel_data,
  output logic [7:0] out_byte,
  output logic       last_of_flush,
  output logic       request_rejected
);

  logic [7:0] mem [MEM_DEPTH];
  logic [7:0] rdata;

  logic              flush_busy;
  logic [PAGE_W-1:0] current_page;
  logic [PAGE_W-1:0] last_page;
  logic [COL_W-1:0]  first_column;
  logic [7:0]        column_count;
  logic [7:0]        page_position;
  logic [2:0]        row_lo;
  logic [2:0]        row_hi;

  logic [PAGE_W-1:0] inv_page;
  logic [COL_W-1:0]  inv_col;
  logic [ADDR_W-1:0] rmw_addr;
  logic [7:0]        rmw_mask;
  logic              rmw_last;
  logic [ADDR_W-1:0] clr_addr;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [PAGE_W-1:0] pg,
                                                input logic [COL_W-1:0] col);
    addr_of = ADDR_W'(pg) * ADDR_W'(COLUMN_COUNT) + ADDR_W'(col);
  endfunction

  function automatic logic [7:0] row_mask(input logic [2:0] lo, input logic [2:0] hi);
    row_mask = (8'hFF << lo) & (8'hFF >> (3'd7 - hi));
  endfunction

  // rectangle clipping
  logic [8:0] sc9, sr9, sum_c, sum_r, end_c, end_r, er_m1;
  logic       rect_empty;

  always_comb begin
    sc9   = {2'b00, start_column};
    sr9   = {3'b000, start_row};
    sum_c = sc9 + {1'b0, region_width};
    sum_r = sr9 + {1'b0, region_height};
    end_c = (sum_c > 9'(COLUMN_COUNT)) ? 9'(COLUMN_COUNT) : sum_c;
    end_r = (sum_r > 9'(ROW_COUNT)) ? 9'(ROW_COUNT) : sum_r;
    er_m1 = end_r - 9'd1;
    rect_empty = (region_width == 8'd0) || (region_height == 8'd0) ||
                 (sc9 >= 9'(COLUMN_COUNT)) || (sr9 >= 9'(ROW_COUNT));
  end

  // invert sweep
  logic [8:0]        last_col9;
  logic              inv_col_end;
  logic [2:0]        mask_lo, mask_hi;
  logic [ADDR_W-1:0] inv_addr;

  always_comb begin
    last_col9   = {2'b00, first_column} + {1'b0, column_count} - 9'd1;
    inv_col_end = (inv_col == COL_W'(last_col9));
    mask_lo     = (inv_page == current_page) ? row_lo : 3'd0;
    mask_hi     = (inv_page == last_page) ? row_hi : 3'd7;
    inv_addr    = addr_of(inv_page, inv_col);
  end

  // flush sequencing
  logic [8:0]        pull_col9;
  logic [ADDR_W-1:0] pull_addr;
  logic              page_end;
  logic              flush_last;
  logic [7:0]        fc8;

  always_comb begin
    pull_col9  = {2'b00, first_column} + {1'b0, page_position} - 9'd3;
    pull_addr  = addr_of(current_page, COL_W'(pull_col9));
    page_end   = ({1'b0, page_position} >= ({1'b0, column_count} + 9'd2));
    flush_last = page_end && (current_page >= last_page);
    fc8        = 8'(first_column);
  end

  // frame store
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;

  always_comb begin
    mem_we    = cmd.clr_wr || cmd.inv_wr;
    mem_waddr = cmd.clr_wr ? clr_addr : rmw_addr;
    mem_wdata = cmd.clr_wr ? 8'h00 : (rdata ^ rmw_mask);
    mem_re    = cmd.inv_rd || cmd.pull_rd;
    mem_raddr = cmd.inv_rd ? inv_addr : pull_addr;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flush_busy    <= 1'b0;
      current_page  <= '0;
      last_page     <= '0;
      first_column  <= '0;
      column_count  <= '0;
      page_position <= '0;
    end else if (cmd.start_inv) begin
      flush_busy    <= 1'b1;
      current_page  <= PAGE_W'(sr9 >> 3);
      last_page     <= PAGE_W'(er_m1 >> 3);
      first_column  <= COL_W'(start_column);
      column_count  <= 8'(end_c - sc9);
      page_position <= '0;
    end else if (cmd.pull_out) begin
      if (page_end) begin
        page_position <= '0;
        if (flush_last) begin
          flush_busy <= 1'b0;
        end else begin
          current_page <= current_page + PAGE_W'(1);
        end
      end else begin
        page_position <= page_position + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_inv) begin
      row_lo   <= start_row[2:0];
      row_hi   <= er_m1[2:0];
      inv_page <= PAGE_W'(sr9 >> 3);
      inv_col  <= COL_W'(start_column);
    end else if (cmd.inv_rd) begin
      rmw_addr <= inv_addr;
      rmw_mask <= row_mask(mask_lo, mask_hi);
      rmw_last <= inv_col_end && (inv_page == last_page);
      if (inv_col_end) begin
        inv_col  <= first_column;
        inv_page <= inv_page + PAGE_W'(1);
      end else begin
        inv_col <= inv_col + COL_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.res_imm) begin
      byte_valid       <= 1'b0;
      is_pixel_data    <= 1'b0;
      out_byte         <= 8'h00;
      last_of_flush    <= 1'b0;
      request_rejected <= cmd.res_rej;
    end else if (cmd.pull_out) begin
      byte_valid       <= 1'b1;
      last_of_flush    <= flush_last;
      request_rejected <= 1'b0;
      unique case (page_position)
        POS_PAGE: begin
          out_byte      <= PAGE_CMD + 8'(current_page);
          is_pixel_data <= 1'b0;
        end
        POS_COL_LO: begin
          out_byte      <= COL_LO_CMD + (fc8 & NIBBLE_MASK);
          is_pixel_data <= 1'b0;
        end
        POS_COL_HI: begin
          out_byte      <= COL_HI_CMD + ((fc8 >> 4) & NIBBLE_MASK);
          is_pixel_data <= 1'b0;
        end
        default: begin
          out_byte      <= rdata;
          is_pixel_data <= 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    sts.busy       = flush_busy;
    sts.rect_empty = rect_empty;
    sts.clr_last   = (clr_addr == ADDR_W'(MEM_DEPTH - 1));
    sts.inv_last   = rmw_last;
  end

endmodule

// ===== rtl/pfif_ctrl.sv =====
module pfif_ctrl import pfif_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      operation,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  pfif_sts_t sts,
  output pfif_cmd_t cmd
);

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_INV_RD   = 3'd2;
  localparam logic [2:0] S_INV_WR   = 3'd3;
  localparam logic [2:0] S_PULL_OUT = 3'd4;

  logic [2:0] state, state_next;
  logic       out_valid_next;
  logic       accept;

  always_comb begin
    in_ready       = (state == S_IDLE) && (!out_valid || out_ready);
    accept         = in_valid && in_ready;
    cmd            = '0;
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (operation == OP_INVERT) begin
            cmd.res_imm    = 1'b1;
            cmd.res_rej    = sts.busy;
            out_valid_next = 1'b1;
            if (!sts.busy && !sts.rect_empty) begin
              cmd.start_inv = 1'b1;
              state_next    = S_INV_RD;
            end
          end else if (!sts.busy) begin
            cmd.res_imm    = 1'b1;
            out_valid_next = 1'b1;
          end else begin
            cmd.pull_rd = 1'b1;
            state_next  = S_PULL_OUT;
          end
        end
      end
      S_INV_RD: begin
        cmd.inv_rd = 1'b1;
        state_next = S_INV_WR;
      end
      S_INV_WR: begin
        cmd.inv_wr = 1'b1;
        state_next = sts.inv_last ? S_IDLE : S_INV_RD;
      end
      S_PULL_OUT: begin
        cmd.pull_out   = 1'b1;
        out_valid_next = 1'b1;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // a result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.res_imm || cmd.pull_out) |-> (!out_valid || out_ready))
    else $error("result register overwritten");

  // the clearing pass runs once, only after reset
  a_clear_once: assert property (@(posedge clk) disable iff (rst)
    (state != S_CLEAR) |=> (state != S_CLEAR))
    else $error("clearing pass re-entered");

  // a write-back always follows its read
  a_rmw_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_INV_WR) |-> ($past(state) == S_INV_RD))
    else $error("write-back without read");

  // a pull result follows an accepted pull while a flush is pending
  a_pull_source: assert property (@(posedge clk) disable iff (rst)
    (state == S_PULL_OUT) |-> ($past(accept) && $past(sts.busy)))
    else $error("pull result without pending flush");

endmodule

// ===== rtl/page_framebuffer_invert_flush.sv =====
// an invert is answered in the cycle after acceptance; unless rejected or empty, its
// rectangle is then flipped by read-modify-write, a read state and a write state per
// covered column byte, before the next request; a pull with a flush pending goes through
// the registered frame store read port, then the result register, taking no request until
// its result is loaded; reset (synchronous, active high) clears the flush state, then a
// clearing pass zeroes all 1024 frame store bytes, one a cycle, taking no request till done
module page_framebuffer_invert_flush import pfif_pkg::*; (
  input  logic clk,
  input  logic rst,
  pfif_in_if.sink    item,
  pfif_out_if.source result
);

  // command and status between sequencer and datapath
  pfif_cmd_t cmd;
  pfif_sts_t sts;

  // sequencer: clearing pass, request dispatch, invert sweep, pull timing,
  // and the valid flag of the result register
  pfif_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .operation (item.operation),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: frame store, clipping, flush position registers and result payload
  pfif_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .start_column     (item.start_column),
    .start_row        (item.start_row),
    .region_width     (item.region_width),
    .region_height    (item.region_height),
    .sts              (sts),
    .byte_valid       (result.byte_valid),
    .is_pixel_data    (result.is_pixel_data),
    .out_byte         (result.out_byte),
    .last_of_flush    (result.last_of_flush),
    .request_rejected (result.request_rejected)
  );

endmodule

// ===== tb/page_framebuffer_invert_flush_tb.sv =====
`timescale 1ns / 1ps

module page_framebuffer_invert_flush_tb;
  import pfif_pkg::*;

  localparam int MAX_IDLE      = 10;
  localparam int RANDOM_ITEMS  = 180;
  // longest quiet spell of the block: a full-screen flip, a read and a write per byte
  localparam int DRAIN_CYCLES  = 2 * MEM_DEPTH + 64;

  // one reply of the block, as it appears on the result channel
  typedef struct packed {
    logic       byte_valid;
    logic       is_pixel_data;
    logic [7:0] out_byte;
    logic       last_of_flush;
    logic       request_rejected;
  } panel_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pfif_in_if  request_bus ();
  pfif_out_if reply_bus ();

  page_framebuffer_invert_flush u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (request_bus),
    .result (reply_bus)
  );

  always #4 clk = ~clk;

  // shadow copy of the panel memory and of the flush walker
  logic [7:0]        shadow_frame [0:MEM_DEPTH-1];
  logic              flush_pending;
  logic [PAGE_W-1:0] flush_page;
  logic [PAGE_W-1:0] flush_last_page;
  logic [COL_W-1:0]  flush_first_col;
  logic [7:0]        flush_col_count;
  logic [7:0]        flush_pos;

  panel_reply_t pending_replies [$];

  // when set, neither side idles
  logic steady = 1'b0;

  int mismatches     = 0;
  int useful_items   = 0;
  int inverts_done   = 0;
  int bytes_pulled   = 0;
  int rejects_seen   = 0;
  int flushes_closed = 0;

  // ---------------------------------------------------------------------------
  // reply prediction, applied at the edge where a request is taken
  // ---------------------------------------------------------------------------
  function automatic panel_reply_t predict_panel_reply(logic op, logic [6:0] sc,
                                                       logic [5:0] sr, logic [7:0] w,
                                                       logic [7:0] h);
    panel_reply_t r;
    int end_col;
    int end_row;
    int col;
    r = '0;
    if (op == OP_INVERT) begin
      if (flush_pending) begin
        r.request_rejected = 1'b1;
      end else if (w != 0 && h != 0 && sc < COLUMN_COUNT && sr < ROW_COUNT) begin
        // clip to the screen edges
        end_col = int'(sc) + int'(w);
        if (end_col > COLUMN_COUNT) end_col = COLUMN_COUNT;
        end_row = int'(sr) + int'(h);
        if (end_row > ROW_COUNT) end_row = ROW_COUNT;
        for (int c = int'(sc); c < end_col; c++) begin
          for (int rw = int'(sr); rw < end_row; rw++) begin
            shadow_frame[(rw / 8) * COLUMN_COUNT + c][rw % 8] =
              ~shadow_frame[(rw / 8) * COLUMN_COUNT + c][rw % 8];
          end
        end
        // arm the flush of the covered pages and columns
        flush_pending   = 1'b1;
        flush_page      = PAGE_W'(sr / 8);
        flush_last_page = PAGE_W'((end_row - 1) / 8);
        flush_first_col = sc;
        flush_col_count = 8'(end_col - int'(sc));
        flush_pos       = POS_PAGE;
      end
    end else if (flush_pending) begin
      r.byte_valid = 1'b1;
      case (flush_pos)
        POS_PAGE:   r.out_byte = PAGE_CMD + 8'(flush_page);
        POS_COL_LO: r.out_byte = COL_LO_CMD + (8'(flush_first_col) & NIBBLE_MASK);
        POS_COL_HI: r.out_byte = COL_HI_CMD + ((8'(flush_first_col) >> 4) & NIBBLE_MASK);
        default: begin
          col = int'(flush_first_col) + int'(flush_pos) - int'(POS_DATA);
          r.is_pixel_data = 1'b1;
          r.out_byte = (col < COLUMN_COUNT) ?
                       shadow_frame[int'(flush_page) * COLUMN_COUNT + col] : 8'h00;
        end
      endcase
      // end of a page once every column byte has gone
      if (flush_pos >= POS_COL_HI && flush_pos - POS_COL_HI >= flush_col_count) begin
        flush_pos = POS_PAGE;
        if (flush_page >= flush_last_page) begin
          r.last_of_flush = 1'b1;
          flush_pending   = 1'b0;
        end else begin
          flush_page = flush_page + PAGE_W'(1);
        end
      end else begin
        flush_pos = flush_pos + 8'd1;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // request side: optional idle gap, then hold valid until the block takes it
  // ---------------------------------------------------------------------------
  task automatic send_request(logic op, logic [6:0] sc, logic [5:0] sr,
                              logic [7:0] w, logic [7:0] h);
    int gap;
    panel_reply_t r;
    gap = steady ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      request_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request_bus.valid         <= 1'b1;
    request_bus.operation     <= op;
    request_bus.start_column  <= sc;
    request_bus.start_row     <= sr;
    request_bus.region_width  <= w;
    request_bus.region_height <= h;
    do @(posedge clk); while (request_bus.ready !== 1'b1);
    // taken at this edge: work out what the block owes us
    r = predict_panel_reply(op, sc, sr, w, h);
    pending_replies.push_back(r);
    if (r.request_rejected) rejects_seen++;
    else if (op == OP_INVERT) inverts_done++;
    if (r.byte_valid) bytes_pulled++;
    if (r.last_of_flush) flushes_closed++;
    // idle pulls and bounced inverts leave the block as it was
    if (!r.request_rejected && (op == OP_INVERT || r.byte_valid)) useful_items++;
  endtask

  task automatic send_pull();
    send_request(OP_PULL, 7'($urandom), 6'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // drain the flush now armed, with the odd bounced invert in between
  task automatic pull_until_flushed(int reject_pct);
    while (flush_pending) begin
      if ($urandom_range(0, 99) < reject_pct)
        send_request(OP_INVERT, 7'($urandom), 6'($urandom), 8'($urandom), 8'($urandom));
      else
        send_pull();
    end
  endtask

  // ---------------------------------------------------------------------------
  // reply side: random stall, then compare with the oldest prediction
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  initial begin : reply_checker
    int stall;
    panel_reply_t want;
    reply_bus.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        reply_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      reply_bus.ready <= 1'b1;
      do @(posedge clk); while (reply_bus.valid !== 1'b1);
      if (pending_replies.size() == 0) begin
        $error("reply with no request waiting");
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        check_field("byte_valid", 8'(want.byte_valid), 8'(reply_bus.byte_valid));
        check_field("is_pixel_data", 8'(want.is_pixel_data), 8'(reply_bus.is_pixel_data));
        check_field("out_byte", want.out_byte, reply_bus.out_byte);
        check_field("last_of_flush", 8'(want.last_of_flush), 8'(reply_bus.last_of_flush));
        check_field("request_rejected", 8'(want.request_rejected),
                    8'(reply_bus.request_rejected));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // pulls with nothing armed, and rectangles with no area
  task automatic test_idle_and_empty();
    send_pull();
    send_request(OP_INVERT, 7'd10, 6'd3, 8'd0, 8'd5);
    send_request(OP_INVERT, 7'd10, 6'd3, 8'd5, 8'd0);
    send_request(OP_INVERT, 7'd127, 6'd63, 8'd0, 8'd0);
    send_pull();
  endtask

  // bottom-right pixel, oversized rectangle clipped to one byte; busy invert bounced
  task automatic test_corner_clip();
    send_request(OP_INVERT, 7'd127, 6'd63, 8'd255, 8'd255);
    send_pull();
    send_request(OP_INVERT, 7'd0, 6'd0, 8'd1, 8'd1);
    pull_until_flushed(0);
  endtask

  // top-left pixel, then a rectangle straddling a page boundary
  task automatic test_small_rects();
    send_request(OP_INVERT, 7'd0, 6'd0, 8'd1, 8'd1);
    pull_until_flushed(0);
    send_request(OP_INVERT, 7'd5, 6'd6, 8'd3, 8'd4);
    pull_until_flushed(0);
  endtask

  // full-width band on the bottom page, then a narrow strip down every page
  // at the right edge, both clipped; no idling to keep it quick
  task automatic test_full_span();
    steady = 1'b1;
    send_request(OP_INVERT, 7'd0, 6'd60, 8'd255, 8'd255);
    pull_until_flushed(0);
    send_request(OP_INVERT, 7'd124, 6'd0, 8'd255, 8'd255);
    pull_until_flushed(0);
    steady = 1'b0;
  endtask

  // mostly small flushes with random content; a few clipped wide or tall ones;
  // some noise of idle pulls and empty rectangles
  task automatic test_random_traffic();
    int target;
    int pick;
    target = useful_items + RANDOM_ITEMS;
    while (useful_items < target) begin
      steady = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        if ($urandom_range(0, 1) == 0)
          send_pull();
        else
          send_request(OP_INVERT, 7'($urandom), 6'($urandom),
                       $urandom_range(0, 1) ? 8'd0 : 8'($urandom), 8'd0);
      end else begin
        if (pick == 1)
          send_request(OP_INVERT, 7'($urandom_range(96, 127)), 6'($urandom_range(40, 63)),
                       8'($urandom_range(128, 255)), 8'($urandom_range(128, 255)));
        else
          send_request(OP_INVERT, 7'($urandom), 6'($urandom),
                       8'($urandom_range(1, 16)), 8'($urandom_range(1, 16)));
        pull_until_flushed(10);
      end
    end
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    // known values on every input from the start
    request_bus.valid         <= 1'b0;
    request_bus.operation     <= OP_PULL;
    request_bus.start_column  <= '0;
    request_bus.start_row     <= '0;
    request_bus.region_width  <= '0;
    request_bus.region_height <= '0;
    for (int i = 0; i < MEM_DEPTH; i++) shadow_frame[i] = 8'h00;
    flush_pending   = 1'b0;
    flush_page      = '0;
    flush_last_page = '0;
    flush_first_col = '0;
    flush_col_count = '0;
    flush_pos       = POS_PAGE;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // the clearing pass after reset is covered by waiting on ready
    test_idle_and_empty();
    test_corner_clip();
    test_small_rects();
    test_full_span();
    test_random_traffic();

    request_bus.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    // let any stray reply show itself
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d inverts, %0d bounced inverts, %0d bytes streamed",
             inverts_done, rejects_seen, bytes_pulled);
    $display("%0d flushes ran to their last byte, %0d field mismatches",
             flushes_closed, mismatches);
    if (mismatches == 0 && pending_replies.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // hang guard, well clear of the slowest legal run
  initial begin
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
